@@ rtl/bpts_pkg.sv @@
// Shared types and constants for the bounded priority task scheduler.
// Used by every module in rtl/; depends on nothing.
package bpts_pkg;

  localparam int QUEUE_DEPTH = 256;
  localparam int MAX_WORKERS = 16;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int WCNT_W      = $clog2(MAX_WORKERS + 1);

  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  localparam logic [8:0]  MAX_QUEUE_SIZE_RST = 9'd200;
  localparam logic [4:0]  WORKER_COUNT_RST   = 5'd1;
  localparam logic [31:0] CNT_MAX            = 32'hFFFF_FFFF;
  localparam logic [39:0] BYTES_MAX          = 40'hFF_FFFF_FFFF;

  typedef enum logic [1:0] {
    REQ_SUBMIT   = 2'd0,
    REQ_DISPATCH = 2'd1,
    REQ_COMPLETE = 2'd2
  } req_code_t;

  typedef enum logic {
    REG_MAX_QUEUE_SIZE = 1'b0,
    REG_WORKER_COUNT   = 1'b1
  } reg_idx_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [15:0] task_priority;
    logic [7:0]         camera_id;
    logic [3:0]         algo_type;
    logic [31:0]        task_bytes;
  } req_t;

  typedef struct packed {
    logic               accepted;
    logic               dropped;
    logic               dispatch_valid;
    logic [7:0]         out_camera_id;
    logic [3:0]         out_algo_type;
    logic signed [15:0] out_priority;
    logic [8:0]         queue_count;
    logic [4:0]         in_flight_count;
    logic [31:0]        dropped_count;
    logic [31:0]        processed_count;
    logic [39:0]        queued_bytes;
  } rsp_t;

  typedef struct packed {
    logic signed [15:0] prio;
    logic [7:0]         cam;
    logic [3:0]         kind;
    logic [31:0]        bytes;
  } task_entry_t;

  typedef struct packed {
    logic [QCNT_W-1:0] q_limit;
    logic [WCNT_W-1:0] w_limit;
  } cfg_t;

  typedef struct packed {
    logic capture;
    logic insert;
    logic drop;
    logic pop;
    logic complete;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic       queue_full;
    logic       can_dispatch;
  } status_t;

endpackage

@@ rtl/bpts_regs.sv @@
// Configuration registers behind the APB-style port, with the effective
// queue and worker limits derived from them. Depends on bpts_pkg.
module bpts_regs import bpts_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic [8:0] max_queue_size;
  logic [4:0] worker_count;
  reg_idx_t   reg_idx;
  logic       wr_en;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[2]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_queue_size <= MAX_QUEUE_SIZE_RST;
      worker_count   <= WORKER_COUNT_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_MAX_QUEUE_SIZE: max_queue_size <= pwdata[8:0];
        REG_WORKER_COUNT:   worker_count   <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_MAX_QUEUE_SIZE: prdata = {23'd0, max_queue_size};
      REG_WORKER_COUNT:   prdata = {27'd0, worker_count};
      default:            prdata = '0;
    endcase
  end

  // A zero limit behaves as one; a limit beyond the hardware behaves as its size.
  always_comb begin
    if (max_queue_size == 9'd0) begin
      cfg.q_limit = QCNT_W'(1);
    end else if (32'(max_queue_size) > QUEUE_DEPTH) begin
      cfg.q_limit = QCNT_W'(QUEUE_DEPTH);
    end else begin
      cfg.q_limit = QCNT_W'(max_queue_size);
    end
    if (worker_count == 5'd0) begin
      cfg.w_limit = WCNT_W'(1);
    end else if (32'(worker_count) > MAX_WORKERS) begin
      cfg.w_limit = WCNT_W'(MAX_WORKERS);
    end else begin
      cfg.w_limit = WCNT_W'(worker_count);
    end
  end

endmodule

@@ rtl/bpts_ctrl.sv @@
// Controller state machine: takes one request transaction, orders the
// datapath operation and owns the result valid flag. Depends on bpts_pkg.
module bpts_ctrl import bpts_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    req_valid,
  output logic    req_ready,
  output logic    rsp_valid,
  input  logic    rsp_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state, state_next;
  logic   rsp_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        req_ready   = 1'b1;
        cmd.capture = req_valid;
        if (req_valid) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // The result register must be free, or emptied in this same cycle.
        if (!rsp_valid || rsp_ready) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
          unique case (status.req_type)
            REQ_SUBMIT: begin
              cmd.drop   = status.queue_full;
              cmd.insert = !status.queue_full;
            end
            REQ_DISPATCH: cmd.pop      = status.can_dispatch;
            REQ_COMPLETE: cmd.complete = 1'b1;
            default: ;
          endcase
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.load_out) begin
      rsp_valid_next = 1'b1;
    end else if (rsp_ready) begin
      rsp_valid_next = 1'b0;
    end else begin
      rsp_valid_next = rsp_valid;
    end
  end

endmodule

@@ rtl/bpts_datapath.sv @@
// Datapath: captured request, sorted row of queue cells, counters and the
// result register. Depends on bpts_pkg.
module bpts_datapath import bpts_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  req_t    req_data,
  input  cfg_t    cfg,
  input  cmd_t    cmd,
  output status_t status,
  output rsp_t    rsp_data
);

  req_t              item;
  task_entry_t       entries [QUEUE_DEPTH];
  task_entry_t       new_entry;
  logic [QUEUE_DEPTH-1:0] keep_vec;

  logic [QCNT_W-1:0] entry_count, entry_count_next;
  logic [WCNT_W-1:0] in_flight, in_flight_next;
  logic [31:0]       drop_total, drop_total_next;
  logic [31:0]       done_total, done_total_next;
  logic [39:0]       byte_total, byte_total_next;
  logic [40:0]       byte_sum;
  logic [39:0]       head_bytes;
  rsp_t              rsp_next;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item <= req_data;
    end
  end

  assign new_entry = '{prio:  item.task_priority,
                       cam:   item.camera_id,
                       kind:  item.algo_type,
                       bytes: item.task_bytes};

  // Each cell keeps its task when it is occupied and ranks at or above the
  // new one; the first cell that does not keep takes the new task, and the
  // rest move one place back. A pop moves every cell but the last one place forward.
  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    assign keep_vec[g] = (QCNT_W'(g) < entry_count) &&
                         (entries[g].prio >= item.task_priority);

    if (g == 0) begin : g_head
      always_ff @(posedge clk) begin
        if (cmd.insert) begin
          if (!keep_vec[g]) begin
            entries[g] <= new_entry;
          end
        end else if (cmd.pop) begin
          entries[g] <= entries[g+1];
        end
      end
    end else if (g == QUEUE_DEPTH - 1) begin : g_tail
      always_ff @(posedge clk) begin
        if (cmd.insert && !keep_vec[g]) begin
          entries[g] <= keep_vec[g-1] ? new_entry : entries[g-1];
        end
      end
    end else begin : g_body
      always_ff @(posedge clk) begin
        if (cmd.insert) begin
          if (!keep_vec[g]) begin
            entries[g] <= keep_vec[g-1] ? new_entry : entries[g-1];
          end
        end else if (cmd.pop) begin
          entries[g] <= entries[g+1];
        end
      end
    end
  end

  assign status.req_type     = item.req_type;
  assign status.queue_full   = (entry_count >= cfg.q_limit);
  assign status.can_dispatch = (entry_count != '0) && (in_flight < cfg.w_limit);

  assign byte_sum   = {1'b0, byte_total} + {9'd0, item.task_bytes};
  assign head_bytes = {8'd0, entries[0].bytes};

  always_comb begin
    entry_count_next = entry_count;
    in_flight_next   = in_flight;
    drop_total_next  = drop_total;
    done_total_next  = done_total;
    byte_total_next  = byte_total;
    if (cmd.insert) begin
      entry_count_next = entry_count + 1'b1;
      byte_total_next  = byte_sum[40] ? BYTES_MAX : byte_sum[39:0];
    end
    if (cmd.drop && drop_total != CNT_MAX) begin
      drop_total_next = drop_total + 1'b1;
    end
    if (cmd.pop) begin
      entry_count_next = entry_count - 1'b1;
      in_flight_next   = in_flight + 1'b1;
      byte_total_next  = (byte_total > head_bytes) ? byte_total - head_bytes : '0;
    end
    if (cmd.complete) begin
      if (in_flight != '0) begin
        in_flight_next = in_flight - 1'b1;
      end
      if (done_total != CNT_MAX) begin
        done_total_next = done_total + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
      in_flight   <= '0;
      drop_total  <= '0;
      done_total  <= '0;
      byte_total  <= '0;
    end else begin
      entry_count <= entry_count_next;
      in_flight   <= in_flight_next;
      drop_total  <= drop_total_next;
      done_total  <= done_total_next;
      byte_total  <= byte_total_next;
    end
  end

  always_comb begin
    rsp_next                 = '0;
    rsp_next.accepted        = cmd.insert;
    rsp_next.dropped         = cmd.drop;
    rsp_next.dispatch_valid  = cmd.pop;
    if (cmd.pop) begin
      rsp_next.out_camera_id = entries[0].cam;
      rsp_next.out_algo_type = entries[0].kind;
      rsp_next.out_priority  = entries[0].prio;
    end
    rsp_next.queue_count     = 9'(entry_count_next);
    rsp_next.in_flight_count = 5'(in_flight_next);
    rsp_next.dropped_count   = drop_total_next;
    rsp_next.processed_count = done_total_next;
    rsp_next.queued_bytes    = byte_total_next;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      rsp_data <= rsp_next;
    end
  end

endmodule

@@ rtl/bounded_priority_task_scheduler.sv @@
// Bounded priority task scheduler. Each request transaction (submit,
// dispatch or completion) yields exactly one result transaction that reports
// the outcome and all counters as they stand after the request. A request
// is captured in the idle state; in the execute state the row of sorted
// queue cells inserts or pops in parallel and the counters update. A new
// request is accepted while the previous result still waits in the output
// register; a request waits in the execute state only if that result has not
// been taken yet. The queue holds QUEUE_DEPTH tasks ordered by priority, with
// earlier arrival first among equal priorities; no clearing pass is needed
// after reset, since only occupied cells are ever read.
//
// Top level: joins the register block, the controller and the datapath.
// Depends on bpts_pkg, bpts_regs, bpts_ctrl and bpts_datapath.
module bounded_priority_task_scheduler import bpts_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  req_t              req_data,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output rsp_t              rsp_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;

  bpts_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bpts_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .status    (status),
    .cmd       (cmd)
  );

  bpts_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .req_data (req_data),
    .cfg      (cfg),
    .cmd      (cmd),
    .status   (status),
    .rsp_data (rsp_data)
  );

  // At most one queue or counter operation per request.
  a_one_op: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.insert, cmd.drop, cmd.pop, cmd.complete}))
    else $error("more than one datapath operation in a cycle");

  // An accepted request occupies the block while it executes.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request accepted while the previous one executes");

  // A pending result is never overwritten.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> !rsp_valid || rsp_ready)
    else $error("result register loaded while a result is pending");

  // Task fields are zero unless a task was dispatched.
  a_zero_when_idle: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_data.dispatch_valid |->
      rsp_data.out_camera_id == '0 && rsp_data.out_algo_type == '0 &&
      rsp_data.out_priority == '0)
    else $error("task fields set without a dispatch");

endmodule

@@ verif/testbench.sv @@
// Self-checking testbench for bounded_priority_task_scheduler: a queue-fed request
// driver, a response monitor and a scheduling predictor, plus APB register access.
// Depends on bpts_pkg and the scheduler RTL only.
module testbench;
  import bpts_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] REQ_UNKNOWN = 2'd3;
  localparam logic [ADDR_W-1:0] QSIZE_ADDR = {REG_MAX_QUEUE_SIZE, 2'b00};
  localparam logic [ADDR_W-1:0] WORKERS_ADDR = {REG_WORKER_COUNT, 2'b00};
  localparam int HOLD_CYCLES = 300;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req_data = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;

  bounded_priority_task_scheduler uut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req_data(req_data),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp_data(rsp_data),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Predicted scheduler state and register copies.
  task_entry_t task_order[$];
  logic [8:0] cfg_queue_size = MAX_QUEUE_SIZE_RST;
  logic [4:0] cfg_workers = WORKER_COUNT_RST;
  logic [4:0] busy_workers = '0;
  logic [31:0] drop_total = '0;
  logic [31:0] done_total = '0;
  logic [39:0] byte_total = '0;

  req_t request_backlog[$];
  rsp_t pending_outcomes[$];
  int requests_issued = 0;
  int results_checked = 0;
  int error_count = 0;
  int send_gap = 0;
  int stall_left = 0;
  int hold_requests = 0;
  int hold_served = 0;
  bit idle_on = 1'b1;

  function automatic void note_failure(string what, logic [63:0] want, logic [63:0] got);
    error_count++;
    if (error_count <= 10)
      $display("mismatch %s: expected %0h, got %0h", what, want, got);
  endfunction

  function automatic void compare_field(string what, logic [63:0] want, logic [63:0] got);
    if (got !== want) note_failure(what, want, got);
  endfunction

  function automatic rsp_t schedule_request(req_t r);
    rsp_t res;
    task_entry_t head;
    task_entry_t fresh;
    int pos;
    int q_lim;
    int w_lim;
    logic [40:0] sum;
    logic [39:0] head_bytes;
    res = '0;
    q_lim = (cfg_queue_size == 0) ? 1 :
            (cfg_queue_size > QUEUE_DEPTH) ? QUEUE_DEPTH : int'(cfg_queue_size);
    w_lim = (cfg_workers == 0) ? 1 :
            (cfg_workers > MAX_WORKERS) ? MAX_WORKERS : int'(cfg_workers);
    case (r.req_type)
      REQ_SUBMIT: begin
        if (task_order.size() >= q_lim) begin
          res.dropped = 1'b1;
          if (drop_total != CNT_MAX) drop_total++;
        end else begin
          // Equal priorities keep arrival order: insert after every peer.
          pos = 0;
          while (pos < task_order.size() &&
                 $signed(task_order[pos].prio) >= $signed(r.task_priority))
            pos++;
          fresh.prio = r.task_priority;
          fresh.cam = r.camera_id;
          fresh.kind = r.algo_type;
          fresh.bytes = r.task_bytes;
          task_order.insert(pos, fresh);
          sum = {1'b0, byte_total} + {9'd0, r.task_bytes};
          byte_total = sum[40] ? BYTES_MAX : sum[39:0];
          res.accepted = 1'b1;
        end
      end
      REQ_DISPATCH: begin
        if (task_order.size() > 0 && busy_workers < w_lim) begin
          head = task_order.pop_front();
          head_bytes = {8'd0, head.bytes};
          byte_total = (byte_total > head_bytes) ? byte_total - head_bytes : '0;
          busy_workers++;
          res.dispatch_valid = 1'b1;
          res.out_camera_id = head.cam;
          res.out_algo_type = head.kind;
          res.out_priority = head.prio;
        end
      end
      REQ_COMPLETE: begin
        if (busy_workers > 0) busy_workers--;
        if (done_total != CNT_MAX) done_total++;
      end
      default: ;
    endcase
    res.queue_count = 9'(task_order.size());
    res.in_flight_count = busy_workers;
    res.dropped_count = drop_total;
    res.processed_count = done_total;
    res.queued_bytes = byte_total;
    return res;
  endfunction

  // Request driver: presents backlog items, with random idle bursts between them.
  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && req_ready)
        pending_outcomes.push_back(schedule_request(req_data));
      if (!req_valid || req_ready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          req_valid <= 1'b0;
        end else if (request_backlog.size() > 0) begin
          req_data <= request_backlog.pop_front();
          req_valid <= 1'b1;
          if (idle_on && $urandom_range(0, 7) == 0) send_gap <= $urandom_range(1, 17);
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // Response monitor: checks each result transaction and throttles rsp_ready.
  always @(posedge clk) begin
    rsp_t want;
    if (!rst) begin
      if (rsp_valid && rsp_ready) begin
        if (pending_outcomes.size() == 0) begin
          note_failure("unexpected result", 64'd0, 64'(rsp_data.queue_count));
        end else begin
          want = pending_outcomes.pop_front();
          results_checked <= results_checked + 1;
          compare_field("accepted", 64'(want.accepted), 64'(rsp_data.accepted));
          compare_field("dropped", 64'(want.dropped), 64'(rsp_data.dropped));
          compare_field("dispatch_valid", 64'(want.dispatch_valid),
                        64'(rsp_data.dispatch_valid));
          compare_field("out_camera_id", 64'(want.out_camera_id),
                        64'(rsp_data.out_camera_id));
          compare_field("out_algo_type", 64'(want.out_algo_type),
                        64'(rsp_data.out_algo_type));
          compare_field("out_priority", 64'(want.out_priority),
                        64'(rsp_data.out_priority));
          compare_field("queue_count", 64'(want.queue_count), 64'(rsp_data.queue_count));
          compare_field("in_flight_count", 64'(want.in_flight_count),
                        64'(rsp_data.in_flight_count));
          compare_field("dropped_count", 64'(want.dropped_count),
                        64'(rsp_data.dropped_count));
          compare_field("processed_count", 64'(want.processed_count),
                        64'(rsp_data.processed_count));
          compare_field("queued_bytes", 64'(want.queued_bytes),
                        64'(rsp_data.queued_bytes));
        end
      end
      if (hold_served != hold_requests) begin
        hold_served <= hold_requests;
        stall_left <= HOLD_CYCLES;
        rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        rsp_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        stall_left <= $urandom_range(0, 16);
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= 1'b1;
      end
    end
  end

  function automatic void queue_request(logic [1:0] kind, logic [15:0] prio,
                                        logic [7:0] cam, logic [3:0] algo,
                                        logic [31:0] bytes);
    req_t r;
    r.req_type = kind;
    r.task_priority = prio;
    r.camera_id = cam;
    r.algo_type = algo;
    r.task_bytes = bytes;
    request_backlog.push_back(r);
    requests_issued++;
  endfunction

  // Random request; percentages of submit, dispatch and completion, the rest unknown.
  function automatic void queue_random(int sub_pct, int disp_pct, int comp_pct);
    int pick;
    logic [1:0] kind;
    logic [15:0] prio;
    logic [31:0] bytes;
    pick = $urandom_range(0, 99);
    if (pick < sub_pct) kind = REQ_SUBMIT;
    else if (pick < sub_pct + disp_pct) kind = REQ_DISPATCH;
    else if (pick < sub_pct + disp_pct + comp_pct) kind = REQ_COMPLETE;
    else kind = REQ_UNKNOWN;
    case ($urandom_range(0, 3))
      0: prio = 16'($signed($urandom_range(0, 4)) - 2);
      1: prio = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
      default: prio = 16'($urandom);
    endcase
    case ($urandom_range(0, 9))
      0: bytes = '0;
      1: bytes = '1;
      default: bytes = $urandom;
    endcase
    queue_request(kind, prio, 8'($urandom), 4'($urandom), bytes);
  endfunction

  task automatic wait_for_outcomes();
    do @(posedge clk); while (results_checked != requests_issued);
  endtask

  task automatic apb_write(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic apb_read(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] want, string what);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= addr;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    compare_field(what, 64'(want), 64'(prdata));
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Upper data bits are random; the register keeps only its own width.
  task automatic set_limits(logic [8:0] qsize, logic [4:0] workers);
    logic [DATA_W-1:0] noise;
    noise = $urandom;
    apb_write(QSIZE_ADDR, {noise[DATA_W-1:9], qsize});
    cfg_queue_size = qsize;
    noise = $urandom;
    apb_write(WORKERS_ADDR, {noise[DATA_W-1:5], workers});
    cfg_workers = workers;
    apb_read(QSIZE_ADDR, {{(DATA_W - 9){1'b0}}, qsize}, "max_queue_size readback");
    apb_read(WORKERS_ADDR, {{(DATA_W - 5){1'b0}}, workers}, "worker_count readback");
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    apb_read(QSIZE_ADDR, {{(DATA_W - 9){1'b0}}, MAX_QUEUE_SIZE_RST}, "max_queue_size reset");
    apb_read(WORKERS_ADDR, {{(DATA_W - 5){1'b0}}, WORKER_COUNT_RST}, "worker_count reset");

    // Directed: empty dispatch, idle completion, unknown type, extremes and ties.
    queue_request(REQ_DISPATCH, '0, '0, '0, '0);
    queue_request(REQ_COMPLETE, '1, '1, '1, '1);
    queue_request(REQ_UNKNOWN, '1, '1, '1, '1);
    queue_request(REQ_SUBMIT, 16'h0000, 8'h00, 4'h0, 32'h0000_0000);
    queue_request(REQ_SUBMIT, 16'h7FFF, 8'hFF, 4'hF, 32'hFFFF_FFFF);
    queue_request(REQ_SUBMIT, 16'h8000, 8'hA5, 4'h5, 32'h0000_0001);
    queue_request(REQ_SUBMIT, 16'h7FFF, 8'h01, 4'h1, 32'h8000_0000);
    queue_request(REQ_SUBMIT, 16'hFFFF, 8'h5A, 4'hA, 32'h7FFF_FFFF);
    queue_request(REQ_SUBMIT, 16'h0000, 8'h02, 4'h2, 32'h0000_FFFF);
    queue_request(REQ_DISPATCH, '0, '0, '0, '0);
    // One worker only: the second dispatch must be refused.
    queue_request(REQ_DISPATCH, '1, '1, '1, '1);
    repeat (5) begin
      queue_request(REQ_COMPLETE, '0, '0, '0, '0);
      queue_request(REQ_DISPATCH, '0, '0, '0, '0);
    end
    queue_request(REQ_COMPLETE, '0, '0, '0, '0);
    queue_request(REQ_DISPATCH, '0, '0, '0, '0);
    wait_for_outcomes();

    // Zero queue limit and zero workers both act as one.
    set_limits(9'd0, 5'd0);
    repeat (30) queue_random(45, 30, 20);
    wait_for_outcomes();

    // Full storage and worker limits, with a long receiver hold-off.
    set_limits(9'd256, 5'd16);
    repeat (10) queue_random(50, 30, 15);
    hold_requests++;
    repeat (40) queue_random(50, 30, 15);
    wait_for_outcomes();

    set_limits(9'd1, 5'd2);
    repeat (30) queue_random(40, 35, 20);
    wait_for_outcomes();

    // Limits beyond storage and worker count; fill to capacity with no idling.
    idle_on = 1'b0;
    set_limits(9'd511, 5'd31);
    repeat (260) queue_random(100, 0, 0);
    repeat (20) queue_random(0, 100, 0);
    repeat (20) queue_random(0, 0, 100);
    repeat (10) queue_random(0, 100, 0);
    repeat (5) queue_random(0, 0, 100);
    wait_for_outcomes();

    repeat (20) @(posedge clk);
    if (pending_outcomes.size() != 0)
      note_failure("results left over", 64'd0, 64'(pending_outcomes.size()));
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
